@@ rtl/core/jsu_pkg.sv @@
`default_nettype none

package jsu_pkg;

    // Decoder modes
    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_PLAIN,
        MODE_ESC,
        MODE_HEX_HI,
        MODE_WANT_BS,
        MODE_WANT_U,
        MODE_HEX_LO
    } t_mode;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    // Error codes
    typedef enum logic [3:0] {
        ERR_NONE       = 4'd0,
        ERR_UNTERM     = 4'd1,
        ERR_CONTROL    = 4'd2,
        ERR_ESC_END    = 4'd3,
        ERR_BAD_ESC    = 4'd4,
        ERR_HEX_TRUNC  = 4'd5,
        ERR_BAD_HEX    = 4'd6,
        ERR_LONE_HIGH  = 4'd7,
        ERR_BAD_LOW    = 4'd8,
        ERR_LONE_LOW   = 4'd9
    } t_err;

    // Up to four results produced by one input transaction
    typedef struct packed {
        logic [2:0]      cnt;
        t_kind           kind;
        t_err            code;
        logic [3:0][7:0] bytes;
    } t_bundle;

    // Hex digit decode: bad flag and nibble
    typedef struct packed {
        logic       bad;
        logic [3:0] val;
    } t_hex;

    localparam logic [15:0] SUR_HI_MIN = 16'hD800;
    localparam logic [15:0] SUR_HI_MAX = 16'hDBFF;
    localparam logic [15:0] SUR_LO_MIN = 16'hDC00;
    localparam logic [15:0] SUR_LO_MAX = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;
    localparam logic [20:0] CP_1B_END  = 21'h80;
    localparam logic [20:0] CP_2B_END  = 21'h800;
    localparam logic [7:0]  CTRL_END   = 8'h20;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_F = 8'h66;
    localparam logic [7:0] CH_N = 8'h6E;
    localparam logic [7:0] CH_R = 8'h72;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_U = 8'h75;

    function automatic t_hex hex_val(input logic [7:0] c);
        t_hex h;
        h = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.val = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.val = 4'(c - 8'h37);
        end else begin
            h.bad = 1'b1;
        end
        return h;
    endfunction

    function automatic t_bundle one_result(input t_kind k, input t_err e, input logic [7:0] b);
        t_bundle r;
        r = '0;
        r.cnt = 3'd1;
        r.kind = k;
        r.code = e;
        r.bytes[0] = b;
        return r;
    endfunction

    function automatic t_bundle utf8_bundle(input logic [20:0] cp);
        t_bundle r;
        r = '0;
        r.kind = KIND_DATA;
        r.code = ERR_NONE;
        if (cp < CP_1B_END) begin
            r.cnt = 3'd1;
            r.bytes[0] = {1'b0, cp[6:0]};
        end else if (cp < CP_2B_END) begin
            r.cnt = 3'd2;
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp < SUPP_BASE) begin
            r.cnt = 3'd3;
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            r.cnt = 3'd4;
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/jsu_decode.sv @@
`default_nettype none

module jsu_decode
    import jsu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_text_byte,
    input  wire logic       i_starts_string,
    input  wire logic       i_text_ends,
    output t_bundle         o_bundle
);

    t_mode       r_mode, n_mode;
    logic [1:0]  r_cnt, n_cnt;
    logic [15:0] r_acc, n_acc;
    logic [9:0]  r_hi, n_hi;
    logic        r_bad, n_bad;

    t_mode       e_mode;
    logic [1:0]  e_cnt;
    logic [15:0] e_acc;
    logic [9:0]  e_hi;
    logic        e_bad;

    t_hex        hv;
    logic [15:0] acc_sh;
    logic        bad_sh;
    logic        hex_done;
    logic [20:0] pair_cp;
    t_bundle     bundle;

    // Hold decoder state, update on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_cnt  <= '0;
            r_acc  <= '0;
            r_hi   <= '0;
            r_bad  <= 1'b0;
        end else if (i_take) begin
            r_mode <= n_mode;
            r_cnt  <= n_cnt;
            r_acc  <= n_acc;
            r_hi   <= n_hi;
            r_bad  <= n_bad;
        end
    end

    // Decode one byte against the current state
    always_comb begin
        e_mode = r_mode;
        e_cnt  = r_cnt;
        e_acc  = r_acc;
        e_hi   = r_hi;
        e_bad  = r_bad;
        if (i_starts_string) begin
            e_mode = MODE_PLAIN;
            e_cnt  = '0;
            e_acc  = '0;
            e_hi   = '0;
            e_bad  = 1'b0;
        end

        hv       = hex_val(i_text_byte);
        acc_sh   = {e_acc[11:0], hv.val};
        bad_sh   = e_bad | hv.bad;
        hex_done = (e_cnt == 2'd3);
        pair_cp  = SUPP_BASE + {1'b0, e_hi, acc_sh[9:0]};

        n_mode = e_mode;
        n_cnt  = e_cnt;
        n_acc  = e_acc;
        n_hi   = e_hi;
        n_bad  = e_bad;
        bundle = '0;

        if (i_text_ends) begin
            n_mode = MODE_IDLE;
            case (e_mode)
                MODE_PLAIN:   bundle = one_result(KIND_ERR, ERR_UNTERM, 8'h00);
                MODE_ESC:     bundle = one_result(KIND_ERR, ERR_ESC_END, 8'h00);
                MODE_HEX_HI,
                MODE_HEX_LO:  bundle = one_result(KIND_ERR, ERR_HEX_TRUNC, 8'h00);
                MODE_WANT_BS,
                MODE_WANT_U:  bundle = one_result(KIND_ERR, ERR_LONE_HIGH, 8'h00);
                default:      bundle = '0;
            endcase
        end else begin
            case (e_mode)
                MODE_PLAIN: begin
                    if (i_text_byte == CH_QUOTE) begin
                        bundle = one_result(KIND_DONE, ERR_NONE, 8'h00);
                        n_mode = MODE_IDLE;
                    end else if (i_text_byte < CTRL_END) begin
                        bundle = one_result(KIND_ERR, ERR_CONTROL, 8'h00);
                        n_mode = MODE_IDLE;
                    end else if (i_text_byte == CH_BSLASH) begin
                        n_mode = MODE_ESC;
                    end else begin
                        bundle = one_result(KIND_DATA, ERR_NONE, i_text_byte);
                    end
                end
                MODE_ESC: begin
                    n_mode = MODE_PLAIN;
                    case (i_text_byte)
                        CH_QUOTE:  bundle = one_result(KIND_DATA, ERR_NONE, CH_QUOTE);
                        CH_BSLASH: bundle = one_result(KIND_DATA, ERR_NONE, CH_BSLASH);
                        CH_SLASH:  bundle = one_result(KIND_DATA, ERR_NONE, CH_SLASH);
                        CH_B:      bundle = one_result(KIND_DATA, ERR_NONE, 8'h08);
                        CH_F:      bundle = one_result(KIND_DATA, ERR_NONE, 8'h0C);
                        CH_N:      bundle = one_result(KIND_DATA, ERR_NONE, 8'h0A);
                        CH_R:      bundle = one_result(KIND_DATA, ERR_NONE, 8'h0D);
                        CH_T:      bundle = one_result(KIND_DATA, ERR_NONE, 8'h09);
                        CH_U: begin
                            n_mode = MODE_HEX_HI;
                            n_cnt  = '0;
                            n_acc  = '0;
                            n_bad  = 1'b0;
                        end
                        default: begin
                            bundle = one_result(KIND_ERR, ERR_BAD_ESC, 8'h00);
                            n_mode = MODE_IDLE;
                        end
                    endcase
                end
                MODE_HEX_HI: begin
                    n_acc = acc_sh;
                    n_bad = bad_sh;
                    n_cnt = hex_done ? 2'd0 : e_cnt + 2'd1;
                    if (hex_done) begin
                        if (bad_sh) begin
                            bundle = one_result(KIND_ERR, ERR_BAD_HEX, 8'h00);
                            n_mode = MODE_IDLE;
                        end else if (acc_sh >= SUR_HI_MIN && acc_sh <= SUR_HI_MAX) begin
                            n_hi   = acc_sh[9:0];
                            n_mode = MODE_WANT_BS;
                        end else if (acc_sh >= SUR_LO_MIN && acc_sh <= SUR_LO_MAX) begin
                            bundle = one_result(KIND_ERR, ERR_LONE_LOW, 8'h00);
                            n_mode = MODE_IDLE;
                        end else begin
                            bundle = utf8_bundle({5'd0, acc_sh});
                            n_mode = MODE_PLAIN;
                        end
                    end
                end
                MODE_WANT_BS: begin
                    if (i_text_byte == CH_BSLASH) begin
                        n_mode = MODE_WANT_U;
                    end else begin
                        bundle = one_result(KIND_ERR, ERR_LONE_HIGH, 8'h00);
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_WANT_U: begin
                    if (i_text_byte == CH_U) begin
                        n_mode = MODE_HEX_LO;
                        n_cnt  = '0;
                        n_acc  = '0;
                        n_bad  = 1'b0;
                    end else begin
                        bundle = one_result(KIND_ERR, ERR_LONE_HIGH, 8'h00);
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_HEX_LO: begin
                    n_acc = acc_sh;
                    n_bad = bad_sh;
                    n_cnt = hex_done ? 2'd0 : e_cnt + 2'd1;
                    if (hex_done) begin
                        if (bad_sh) begin
                            bundle = one_result(KIND_ERR, ERR_BAD_HEX, 8'h00);
                            n_mode = MODE_IDLE;
                        end else if (acc_sh < SUR_LO_MIN || acc_sh > SUR_LO_MAX) begin
                            bundle = one_result(KIND_ERR, ERR_BAD_LOW, 8'h00);
                            n_mode = MODE_IDLE;
                        end else begin
                            bundle = utf8_bundle(pair_cp);
                            n_mode = MODE_PLAIN;
                        end
                    end
                end
                default: begin
                    n_mode = MODE_IDLE;
                end
            endcase
        end
    end

    assign o_bundle = bundle;

endmodule

`default_nettype wire

@@ rtl/core/jsu_emit.sv @@
`default_nettype none

module jsu_emit
    import jsu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  wire t_bundle    i_bundle,
    output logic            o_can_load,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic [1:0]      o_kind,
    output logic [3:0]      o_error_code,
    output logic            o_last_of_run
);

    t_bundle    r_bundle;
    logic [2:0] r_left;
    logic [1:0] r_idx;
    logic       take;

    assign take       = o_out_valid && !i_out_stall;
    assign o_can_load = (r_left == 3'd0) || ((r_left == 3'd1) && !i_out_stall);

    // Load a new run or advance through the current one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_idx  <= '0;
        end else if (i_load && i_bundle.cnt != 3'd0) begin
            r_left <= i_bundle.cnt;
            r_idx  <= '0;
        end else if (take) begin
            r_left <= r_left - 3'd1;
            r_idx  <= r_idx + 2'd1;
        end
    end

    // Hold the payload of the run
    always_ff @(posedge i_clk) begin
        if (i_load && i_bundle.cnt != 3'd0) begin
            r_bundle <= i_bundle;
        end
    end

    assign o_out_valid   = (r_left != 3'd0);
    assign o_out_byte    = r_bundle.bytes[r_idx];
    assign o_kind        = r_bundle.kind;
    assign o_error_code  = r_bundle.code;
    assign o_last_of_run = (r_left == 3'd1);

endmodule

`default_nettype wire

@@ rtl/core/json_string_unescape_utf8_unit.sv @@
// Channel  | Direction | Handshake                   | Payload
// ---------+-----------+-----------------------------+-----------------------------------------
// in       | input     | i_in_valid / o_in_stall     | i_text_byte, i_starts_string, i_text_ends
// out      | output    | o_out_valid / i_out_stall   | o_out_byte, o_kind, o_error_code,
//          |           |                             | o_last_of_run
//
// An input byte is decoded in the cycle it is accepted; its results show in the cycle after.
// Each input yields 0 to 4 results from the result register, one per unstalled cycle.
// A byte giving N results stalls the next input until the last result of its run is taken.
// Reset is synchronous, active low; the decoder returns to idle with no string open.
// A stall on the output holds the current result and stalls the input while a result is held.
`default_nettype none

module json_string_unescape_utf8_unit
    import jsu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_text_byte,
    input  wire logic       i_starts_string,
    input  wire logic       i_text_ends,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic [1:0]      o_kind,
    output logic [3:0]      o_error_code,
    output logic            o_last_of_run
);

    t_bundle bundle;
    logic    can_load;
    logic    take_in;

    assign o_in_stall = !can_load;
    assign take_in    = i_in_valid && can_load;

    // Decode state and per-byte logic
    jsu_decode u_decode (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (take_in),
        .i_text_byte     (i_text_byte),
        .i_starts_string (i_starts_string),
        .i_text_ends     (i_text_ends),
        .o_bundle        (bundle)
    );

    // Result register and run serializer
    jsu_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (take_in),
        .i_bundle      (bundle),
        .o_can_load    (can_load),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_kind        (o_kind),
        .o_error_code  (o_error_code),
        .o_last_of_run (o_last_of_run)
    );

endmodule

`default_nettype wire

@@ rtl/core/jsu_checker.sv @@
`default_nettype none

module jsu_checker
    import jsu_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_out_byte,
    input wire logic [1:0] o_kind,
    input wire logic [3:0] o_error_code,
    input wire logic       o_last_of_run
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_kind) && $stable(o_error_code) && $stable(o_last_of_run))
        else $error("stalled result changed");

    // Data carries no error code; done and error results close their run with a zero byte
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_kind == KIND_DATA && o_error_code == ERR_NONE)
            || (o_kind == KIND_DONE && o_error_code == ERR_NONE && o_out_byte == 8'h00
                && o_last_of_run)
            || (o_kind == KIND_ERR && o_error_code != ERR_NONE && o_out_byte == 8'h00
                && o_last_of_run))
        else $error("inconsistent result fields");

    // Continue a run without a gap
    a_run_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_of_run && !i_out_stall |=> o_out_valid && o_kind == KIND_DATA)
        else $error("run broken before its last result");

    // Stall input only while a run is still pending
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && (!o_last_of_run || i_out_stall))
        else $error("input stalled without pending output");

    // A multi-byte run starts with a UTF-8 lead byte
    a_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_of_run && !$past(o_out_valid && !o_last_of_run)
            && !$past(o_out_valid && i_out_stall) |-> o_out_byte[7:6] == 2'b11)
        else $error("run does not start with a lead byte");

endmodule

bind json_string_unescape_utf8_unit jsu_checker u_jsu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_out_byte    (o_out_byte),
    .o_kind        (o_kind),
    .o_error_code  (o_error_code),
    .o_last_of_run (o_last_of_run)
);

`default_nettype wire

@@ tb/json_string_unescape_utf8_unit_tb.sv @@
`default_nettype none

module json_string_unescape_utf8_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 150;
    localparam int PHASE_ITEMS = 90;

    // One decoded output transaction as the block should present it
    typedef struct packed {
        logic [7:0] value;
        t_kind      kind;
        t_err       code;
        logic       last;
    } t_exp_result;

    // Tracks the decoder state and the results still owed by the block
    class unescape_scoreboard;
        t_mode        mode;
        logic [1:0]   hex_count;
        logic [15:0]  hex_word;
        logic [9:0]   high_half;
        bit           hex_bad;
        t_exp_result  run_results[$];
        t_exp_result  pending_results[$];
        int           mismatches;

        function new();
            reset_decoder();
            mismatches = 0;
        endfunction

        function void reset_decoder();
            mode = MODE_IDLE;
            hex_count = 2'd0;
            hex_word = 16'h0000;
            high_half = 10'h000;
            hex_bad = 1'b0;
        endfunction

        function void emit(logic [7:0] b, t_kind k, t_err e);
            t_exp_result r;
            r.value = b;
            r.kind = k;
            r.code = e;
            r.last = 1'b0;
            run_results = {run_results, r};
        endfunction

        // Report one fault and close the string
        function void abort(t_err e);
            emit(8'h00, KIND_ERR, e);
            mode = MODE_IDLE;
        endfunction

        function void emit_code_point(logic [20:0] cp);
            if (cp < 21'h80) begin
                emit(cp[7:0], KIND_DATA, ERR_NONE);
            end else if (cp < 21'h800) begin
                emit({3'b110, cp[10:6]}, KIND_DATA, ERR_NONE);
                emit({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
            end else if (cp < 21'h10000) begin
                emit({4'b1110, cp[15:12]}, KIND_DATA, ERR_NONE);
                emit({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
                emit({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
            end else begin
                emit({5'b11110, cp[20:18]}, KIND_DATA, ERR_NONE);
                emit({2'b10, cp[17:12]}, KIND_DATA, ERR_NONE);
                emit({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
                emit({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
            end
        endfunction

        function void start_hex(t_mode m);
            mode = m;
            hex_count = 2'd0;
            hex_word = 16'h0000;
            hex_bad = 1'b0;
        endfunction

        // Shift in one digit position; flag when the fourth has arrived
        function bit take_digit(logic [7:0] c);
            logic [3:0] nib;
            nib = 4'h0;
            if (c >= 8'h30 && c <= 8'h39) begin
                nib = c[3:0];
            end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
                nib = c[3:0] + 4'd9;
            end else begin
                hex_bad = 1'b1;
            end
            hex_word = {hex_word[11:0], nib};
            if (hex_count == 2'd3) begin
                hex_count = 2'd0;
                return 1'b1;
            end
            hex_count = hex_count + 2'd1;
            return 1'b0;
        endfunction

        // Advance on one accepted input; returns whether the decoder used it
        function bit decode_byte(logic [7:0] c, bit starts, bit ends);
            bit           consumed;
            logic [15:0]  v;
            consumed = starts || (mode != MODE_IDLE);
            run_results.delete();
            if (starts) begin
                reset_decoder();
                mode = MODE_PLAIN;
            end
            if (ends) begin
                case (mode)
                    MODE_PLAIN: abort(ERR_UNTERM);
                    MODE_ESC: abort(ERR_ESC_END);
                    MODE_HEX_HI, MODE_HEX_LO: abort(ERR_HEX_TRUNC);
                    MODE_WANT_BS, MODE_WANT_U: abort(ERR_LONE_HIGH);
                    default: mode = MODE_IDLE;
                endcase
            end else begin
                case (mode)
                    MODE_PLAIN: begin
                        if (c == CH_QUOTE) begin
                            emit(8'h00, KIND_DONE, ERR_NONE);
                            mode = MODE_IDLE;
                        end else if (c < CTRL_END) begin
                            abort(ERR_CONTROL);
                        end else if (c == CH_BSLASH) begin
                            mode = MODE_ESC;
                        end else begin
                            emit(c, KIND_DATA, ERR_NONE);
                        end
                    end
                    MODE_ESC: begin
                        mode = MODE_PLAIN;
                        case (c)
                            CH_QUOTE, CH_BSLASH, CH_SLASH: emit(c, KIND_DATA, ERR_NONE);
                            CH_B: emit(8'h08, KIND_DATA, ERR_NONE);
                            CH_F: emit(8'h0C, KIND_DATA, ERR_NONE);
                            CH_N: emit(8'h0A, KIND_DATA, ERR_NONE);
                            CH_R: emit(8'h0D, KIND_DATA, ERR_NONE);
                            CH_T: emit(8'h09, KIND_DATA, ERR_NONE);
                            CH_U: start_hex(MODE_HEX_HI);
                            default: abort(ERR_BAD_ESC);
                        endcase
                    end
                    MODE_HEX_HI: begin
                        if (take_digit(c)) begin
                            v = hex_word;
                            if (hex_bad) begin
                                abort(ERR_BAD_HEX);
                            end else if (v >= SUR_HI_MIN && v <= SUR_HI_MAX) begin
                                high_half = v[9:0];
                                mode = MODE_WANT_BS;
                            end else if (v >= SUR_LO_MIN && v <= SUR_LO_MAX) begin
                                abort(ERR_LONE_LOW);
                            end else begin
                                emit_code_point({5'b00000, v});
                                mode = MODE_PLAIN;
                            end
                        end
                    end
                    MODE_WANT_BS: begin
                        if (c == CH_BSLASH) begin
                            mode = MODE_WANT_U;
                        end else begin
                            abort(ERR_LONE_HIGH);
                        end
                    end
                    MODE_WANT_U: begin
                        if (c == CH_U) begin
                            start_hex(MODE_HEX_LO);
                        end else begin
                            abort(ERR_LONE_HIGH);
                        end
                    end
                    MODE_HEX_LO: begin
                        if (take_digit(c)) begin
                            v = hex_word;
                            if (hex_bad) begin
                                abort(ERR_BAD_HEX);
                            end else if (v < SUR_LO_MIN || v > SUR_LO_MAX) begin
                                abort(ERR_BAD_LOW);
                            end else begin
                                emit_code_point(21'h10000 + {1'b0, high_half, v[9:0]});
                                mode = MODE_PLAIN;
                            end
                        end
                    end
                    default: mode = MODE_IDLE;
                endcase
            end
            // Mark the final result of this transaction
            if (run_results.size() > 0) begin
                run_results[run_results.size() - 1].last = 1'b1;
            end
            pending_results = {pending_results, run_results};
            return consumed;
        endfunction

        function void check_result(logic [7:0] b, logic [1:0] k, logic [3:0] e, logic last);
            t_exp_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: byte %02h kind %0d code %0d last %0d",
                         $time, b, k, e, last);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (b !== want.value) begin
                $display("%0t: out_byte expected %02h actual %02h", $time, want.value, b);
                mismatches++;
            end
            if (k !== want.kind) begin
                $display("%0t: kind expected %0d actual %0d", $time, want.kind, k);
                mismatches++;
            end
            if (e !== want.code) begin
                $display("%0t: error_code expected %0d actual %0d", $time, want.code, e);
                mismatches++;
            end
            if (last !== want.last) begin
                $display("%0t: last_of_run expected %0d actual %0d", $time, want.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_text_byte = 8'h00;
    logic       i_starts_string = 1'b0;
    logic       i_text_ends = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [7:0] o_out_byte;
    logic [1:0] o_kind;
    logic [3:0] o_error_code;
    logic       o_last_of_run;

    unescape_scoreboard sb;
    int  send_pct = 12;
    int  recv_pct = 51;
    int  fed_bytes = 0;
    int  quiet_cycles = 0;
    int  hold_left = 0;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;
    bit  opening = 1'b0;

    json_string_unescape_utf8_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_text_byte     (i_text_byte),
        .i_starts_string (i_starts_string),
        .i_text_ends     (i_text_ends),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_kind          (o_kind),
        .o_error_code    (o_error_code),
        .o_last_of_run   (o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Check each output transaction, then pick the next stall value
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                sb.check_result(o_out_byte, o_kind, o_error_code, o_last_of_run);
            end
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_pct);
            end
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[json_string_unescape_utf8_unit] ERROR");
                $finish;
            end
        end
    end

    // Offer one input transaction and hold it until accepted
    task automatic send_item(input logic [7:0] b, input bit starts, input bit ends);
        while ($urandom_range(0, 99) < send_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_text_byte <= b;
        i_starts_string <= starts;
        i_text_ends <= ends;
        do @(posedge i_clk); while (o_in_stall);
        if (sb.decode_byte(b, starts, ends)) begin
            fed_bytes++;
        end
    endtask

    task automatic send_body(input logic [7:0] b);
        send_item(b, opening, 1'b0);
        opening = 1'b0;
    endtask

    task automatic send_end();
        send_item(8'($urandom_range(0, 255)), opening, 1'b1);
        opening = 1'b0;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_body(s[i]);
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) begin
            return 8'h30 + n;
        end
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + n - 8'd10;
    endfunction

    function automatic logic [15:0] pick_high();
        case ($urandom_range(0, 3))
            0: return SUR_HI_MIN;
            1: return SUR_HI_MAX;
            default: return 16'(SUR_HI_MIN + $urandom_range(0, 16'h3FF));
        endcase
    endfunction

    function automatic logic [15:0] pick_low();
        case ($urandom_range(0, 3))
            0: return SUR_LO_MIN;
            1: return SUR_LO_MAX;
            default: return 16'(SUR_LO_MIN + $urandom_range(0, 16'h3FF));
        endcase
    endfunction

    function automatic logic [7:0] pick_escape();
        case ($urandom_range(0, 7))
            0: return CH_QUOTE;
            1: return CH_BSLASH;
            2: return CH_SLASH;
            3: return CH_B;
            4: return CH_F;
            5: return CH_N;
            6: return CH_R;
            default: return CH_T;
        endcase
    endfunction

    task automatic send_u_escape(input logic [15:0] v);
        send_body(CH_BSLASH);
        send_body(CH_U);
        for (int k = 3; k >= 0; k--) begin
            send_body(hex_char(v[k*4 +: 4]));
        end
    endtask

    // One string: random well-formed content, sometimes broken, then a close, a cut or neither
    task automatic send_random_string();
        int          tokens;
        int          pick;
        logic [7:0]  b;
        logic [15:0] v;
        opening = 1'b1;
        tokens = $urandom_range(0, 6);
        for (int t = 0; t < tokens; t++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                do b = 8'($urandom_range(8'h20, 8'hFF)); while (b == CH_QUOTE || b == CH_BSLASH);
                send_body(b);
            end else if (pick < 55) begin
                send_body(CH_BSLASH);
                send_body(pick_escape());
            end else if (pick < 80) begin
                case ($urandom_range(0, 3))
                    0: send_u_escape(16'($urandom_range(0, 16'h7F)));
                    1: send_u_escape(16'($urandom_range(16'h80, 16'h7FF)));
                    2: begin
                        v = 16'($urandom_range(0, 1) ? $urandom_range(16'h800, 16'hD7FF)
                                                     : $urandom_range(16'hE000, 16'hFFFF));
                        send_u_escape(v);
                    end
                    default: begin
                        send_u_escape(pick_high());
                        send_u_escape(pick_low());
                    end
                endcase
            end else if (pick < 90) begin
                send_body(8'($urandom_range(0, 255)));
            end else begin
                case ($urandom_range(0, 6))
                    0: begin
                        send_body(CH_BSLASH);
                        send_body(8'($urandom_range(0, 255)));
                    end
                    1: begin
                        send_body(CH_BSLASH);
                        send_body(CH_U);
                        repeat (4) send_body(8'($urandom_range(0, 255)));
                    end
                    2: send_u_escape(pick_low());
                    3: begin
                        send_u_escape(pick_high());
                        send_body(8'($urandom_range(0, 255)));
                    end
                    4: begin
                        send_u_escape(pick_high());
                        send_body(CH_BSLASH);
                        send_body(8'($urandom_range(0, 255)));
                    end
                    5: begin
                        send_u_escape(pick_high());
                        send_u_escape(16'($urandom_range(0, 16'hFFFF)));
                    end
                    default: send_body(8'($urandom_range(0, 8'h1F)));
                endcase
            end
        end
        // Close the string, cut it short, or leave it open for a restart
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            send_body(CH_QUOTE);
        end else if (pick < 78) begin
            send_end();
        end else if (pick < 88) begin
            case ($urandom_range(0, 2))
                0: send_body(CH_BSLASH);
                1: begin
                    send_body(CH_BSLASH);
                    send_body(CH_U);
                    repeat ($urandom_range(0, 3)) send_body(hex_char(4'($urandom_range(0, 15))));
                end
                default: begin
                    send_u_escape(pick_high());
                    if ($urandom_range(0, 1)) begin
                        send_body(CH_BSLASH);
                    end
                end
            endcase
            send_end();
        end
        // Stray bytes between strings
        if ($urandom_range(0, 4) == 0) begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Idle decoder ignores bytes and text ends
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        // Surrogate pair to four bytes, then close
        opening = 1'b1;
        send_text("\\uD83D\\uDE00\"");
        // Plain extremes, escaped zero, text ends after a backslash
        opening = 1'b1;
        send_body(8'h20);
        send_body(8'hFF);
        send_text("\\u0000\\");
        send_end();
        // Control byte
        opening = 1'b1;
        send_body(8'h1F);
        // Empty text ends at once
        opening = 1'b1;
        send_end();
        // Truncation wins over an earlier bad digit
        opening = 1'b1;
        send_text("\\uG\"");
        send_end();
        // Lone low surrogate
        opening = 1'b1;
        send_text("\\uDC00");

        // Random strings over three idling profiles
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_pct = 12;
                    recv_pct = 51;
                end
                1: begin
                    send_pct = 51;
                    recv_pct = 12;
                end
                default: begin
                    send_pct = 0;
                    recv_pct = 0;
                end
            endcase
            fed_bytes = 0;
            while (fed_bytes < PHASE_ITEMS) begin
                // Long output hold-off while input keeps coming
                if (phase == 0 && fed_bytes >= 40 && !hold_done) begin
                    hold_req = 1'b1;
                    hold_done = 1'b1;
                end
                send_random_string();
            end
        end
        i_in_valid <= 1'b0;

        // Drain, then allow for late or extra results
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("[json_string_unescape_utf8_unit] OK");
        end else begin
            $display("[json_string_unescape_utf8_unit] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
